>>> rtl/zigzag_scan_coordinate_generator_top_defines.svh
// Assertion macros shared by the zigzag scan generator checker.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef ZIGZAG_SCAN_COORDINATE_GENERATOR_TOP_DEFINES_SVH
`define ZIGZAG_SCAN_COORDINATE_GENERATOR_TOP_DEFINES_SVH

// Property checked only while the block is out of reset.
`define ZZSG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("zigzag scan generator assertion failed");

// Property checked on every clock edge, reset included.
`define ZZSG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("zigzag scan generator reset assertion failed");

`endif

>>> rtl/zzsg_pkg.sv
// Types, register codes and constants of the zigzag scan generator.
// Used by the design modules of the block (top, step, orient); depends on nothing.
`default_nettype none

package zzsg_pkg;

  localparam int MaxSideLog2 = 6;

  typedef logic [5:0]  coord_t;
  typedef logic [11:0] index_t;
  typedef logic [2:0]  side_log2_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   up;
  } base_pt_t;

  typedef struct packed {
    side_log2_t side_log2;
    logic [1:0] orientation;
    logic       reverse_order;
  } cfg_t;

  localparam logic [1:0] REG_SIDE_LOG2     = 2'd0;
  localparam logic [1:0] REG_ORIENTATION   = 2'd1;
  localparam logic [1:0] REG_REVERSE_ORDER = 2'd2;

  localparam logic [1:0] ORIENT_NORMAL     = 2'd0;
  localparam logic [1:0] ORIENT_TRANSPOSED = 2'd1;
  localparam logic [1:0] ORIENT_MIRRORED   = 2'd2;
  localparam logic [1:0] ORIENT_MIRR_TRANS = 2'd3;

  function automatic side_log2_t eff_log2(input side_log2_t s);
    if (s > side_log2_t'(MaxSideLog2)) begin
      return side_log2_t'(MaxSideLog2);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/zzsg_step.sv
// Next-point logic: one zigzag step of the base point, with wrap and restart.
// Depends on zzsg_pkg.
`default_nettype none

module zzsg_step (
  input  zzsg_pkg::base_pt_t cur_pt,
  input  zzsg_pkg::index_t   cur_count,
  input  logic               started,
  input  logic               restart,
  input  zzsg_pkg::coord_t   top,
  input  zzsg_pkg::index_t   total_last,
  output zzsg_pkg::base_pt_t nxt_pt,
  output zzsg_pkg::index_t   nxt_count,
  output logic               nxt_last
);
  import zzsg_pkg::*;

  logic   wrap;
  coord_t adv_x;
  coord_t adv_y;

  assign wrap = restart || !started || (cur_count >= total_last);

  always_comb begin
    adv_x = cur_pt.x;
    adv_y = cur_pt.y;
    if (cur_pt.up) begin
      priority if (cur_pt.y == top) begin
        adv_x = cur_pt.x + coord_t'(1);
      end else if (cur_pt.x == '0) begin
        adv_y = cur_pt.y + coord_t'(1);
      end else begin
        adv_x = cur_pt.x - coord_t'(1);
        adv_y = cur_pt.y + coord_t'(1);
      end
    end else begin
      priority if (cur_pt.x == top) begin
        adv_y = cur_pt.y + coord_t'(1);
      end else if (cur_pt.y == '0) begin
        adv_x = cur_pt.x + coord_t'(1);
      end else begin
        adv_x = cur_pt.x + coord_t'(1);
        adv_y = cur_pt.y - coord_t'(1);
      end
    end
  end

  always_comb begin
    if (wrap) begin
      nxt_pt    = '0;
      nxt_count = '0;
    end else begin
      nxt_pt.x  = adv_x;
      nxt_pt.y  = adv_y;
      nxt_pt.up = adv_x[0] ^ adv_y[0];
      nxt_count = cur_count + index_t'(1);
    end
  end

  assign nxt_last = (nxt_count == total_last);

endmodule

`default_nettype wire

>>> rtl/zzsg_orient.sv
// Output mapping: reversal and orientation of a base scan point.
// Depends on zzsg_pkg.
`default_nettype none

module zzsg_orient (
  input  zzsg_pkg::coord_t base_x,
  input  zzsg_pkg::coord_t base_y,
  input  zzsg_pkg::coord_t top,
  input  zzsg_pkg::cfg_t   cfg,
  output zzsg_pkg::coord_t x_coord,
  output zzsg_pkg::coord_t y_coord
);
  import zzsg_pkg::*;

  coord_t u;
  coord_t v;

  assign u = cfg.reverse_order ? (top - base_x) : base_x;
  assign v = cfg.reverse_order ? (top - base_y) : base_y;

  always_comb begin
    unique case (cfg.orientation)
      ORIENT_NORMAL: begin
        x_coord = u;
        y_coord = v;
      end
      ORIENT_TRANSPOSED: begin
        x_coord = v;
        y_coord = u;
      end
      ORIENT_MIRRORED: begin
        x_coord = top - u;
        y_coord = v;
      end
      ORIENT_MIRR_TRANS: begin
        x_coord = top - v;
        y_coord = u;
      end
      default: begin
        x_coord = u;
        y_coord = v;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/zigzag_scan_coordinate_generator_top.sv
// Flow: an accepted request goes into the input register, then into the result
// register once that is empty or being read, which raises the result handshake.
// Throughput: one request per cycle while out_tready does not stall the output.
// Reset: synchronous active-low rst_n restores side_log2 3, normal orientation,
// forward order, and clears the scan so the next request emits the first point.
// Top level of the zigzag scan generator; depends on zzsg_pkg, zzsg_step, zzsg_orient.
`default_nettype none

module zigzag_scan_coordinate_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [5:0] x_coord, [11:6] y_coord, [23:12] point_index
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import zzsg_pkg::*;

  cfg_t       cfg_r;
  side_log2_t eff;
  coord_t     top;
  index_t     total_last;
  logic       cfg_hit;

  logic     a_valid_r;
  logic     a_restart_r;
  logic     a_move;

  base_pt_t pt_r;
  index_t   count_r;
  logic     started_r;

  base_pt_t nxt_pt;
  index_t   nxt_count;
  logic     nxt_last;
  coord_t   map_x;
  coord_t   map_y;

  logic     out_valid_r;
  logic     out_valid_nxt;
  coord_t   out_x_r;
  coord_t   out_y_r;
  index_t   out_index_r;
  logic     out_last_r;

  assign eff        = eff_log2(cfg_r.side_log2);
  assign top        = ~(coord_t'('1) << eff);
  assign total_last = ~(index_t'('1) << {eff, 1'b0});

  assign a_move    = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_move;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     ((cfg_index == REG_SIDE_LOG2) || (cfg_index == REG_ORIENTATION) ||
                      (cfg_index == REG_REVERSE_ORDER));

  zzsg_step u_step (
    .cur_pt     (pt_r),
    .cur_count  (count_r),
    .started    (started_r),
    .restart    (a_restart_r),
    .top        (top),
    .total_last (total_last),
    .nxt_pt     (nxt_pt),
    .nxt_count  (nxt_count),
    .nxt_last   (nxt_last)
  );

  zzsg_orient u_orient (
    .base_x  (nxt_pt.x),
    .base_y  (nxt_pt.y),
    .top     (top),
    .cfg     (cfg_r),
    .x_coord (map_x),
    .y_coord (map_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_restart_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_log2     <= 3'd3;
      cfg_r.orientation   <= ORIENT_NORMAL;
      cfg_r.reverse_order <= 1'b0;
      pt_r                <= '0;
      count_r             <= '0;
      started_r           <= 1'b0;
    end else begin
      if (a_move) begin
        pt_r    <= nxt_pt;
        count_r <= nxt_count;
      end
      if (cfg_hit) begin
        started_r <= 1'b0;
      end else if (a_move) begin
        started_r <= 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SIDE_LOG2: begin
            cfg_r.side_log2 <= cfg_data;
          end
          REG_ORIENTATION: begin
            cfg_r.orientation <= cfg_data[1:0];
          end
          REG_REVERSE_ORDER: begin
            cfg_r.reverse_order <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    if (a_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_x_r     <= map_x;
      out_y_r     <= map_y;
      out_index_r <= nxt_count;
      out_last_r  <= nxt_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/zzsg_checker.sv
// Port-level checker for the zigzag scan generator, bound to the top level.
// Depends on zigzag_scan_coordinate_generator_top_defines.svh.
`default_nettype none

`include "zigzag_scan_coordinate_generator_top_defines.svh"

module zzsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  logic out_stall;
  logic in_take;
  logic first_last;

  assign out_stall  = out_tvalid && !out_tready;
  assign in_take    = in_tvalid && in_tready;
  assign first_last = out_tvalid && out_tlast && (out_tdata[23:12] == 12'd0);

  // A stalled result keeps its contents.
  `ZZSG_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A result appears only for a request that was taken, via the input register.
  `ZZSG_ASSERT(a_out_needs_req, $rose(out_tvalid) |-> $past(in_take, 2))

  // A last point at index zero is the single point of a side-one grid.
  `ZZSG_ASSERT(a_single_point, first_last |-> (out_tdata[11:0] == 12'd0))

  // Reset empties the result register.
  `ZZSG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

bind zigzag_scan_coordinate_generator_top zzsg_checker u_zzsg_checker (.*);

`default_nettype wire
